/* hdl/i2p_pkg.sv */
package i2p_pkg;

	// stack and run limits
	localparam int DEFAULT_STACK_DEPTH = 16;
	localparam int MAX_RUN             = 16;
	localparam int RUN_W               = $clog2(MAX_RUN + 1);

	// characters with a meaning of their own
	localparam logic [7:0] CH_CARET = 8'h5e;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;

	// input word
	typedef struct packed {
		logic [7:0] in_char;
		logic       end_mark;
	} i2p_in_t;

	// output word
	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       run_last;
		logic       expr_done;
		logic       overflow;
	} i2p_out_t;

	// per-cycle command to every stack cell
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctl_t;

	// precedence level: 0 for anything that is not an arithmetic operator
	function automatic logic [1:0] prec_lvl(input logic [7:0] ch);
		logic [1:0] lvl;
		lvl = 2'd0;
		if (ch == CH_CARET) begin
			lvl = 2'd3;
		end else if (ch == CH_STAR || ch == CH_SLASH) begin
			lvl = 2'd2;
		end else if (ch == CH_PLUS || ch == CH_MINUS) begin
			lvl = 2'd1;
		end
		return lvl;
	endfunction

	// digits and ascii letters
	function automatic logic is_operand(input logic [7:0] ch);
		return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h7a) ||
			(ch >= 8'h41 && ch <= 8'h5a);
	endfunction

endpackage

/* hdl/i2p_cell.sv */
module i2p_cell
	import i2p_pkg::*;
(
	input  logic       clk,
	input  stk_ctl_t   ctl,
	input  logic [7:0] from_up,
	input  logic [7:0] from_down,
	output logic [7:0] entry
);

	logic [7:0] entry_q;

	// shift toward the bottom on push, toward the top on pop
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= from_up;
		end else if (ctl.pop) begin
			entry_q <= from_down;
		end
	end

	assign entry = entry_q;

endmodule

/* hdl/infix_to_postfix_converter.sv */
// Infix to postfix converter (shunting yard).
// Input channel src_*: one word per infix character, or an end marker
// (end_mark set) that flushes the operator stack. Output channel dst_*:
// one word per postfix character; run_last marks the last word caused by
// an input word, expr_done the end of a complete flush, overflow a push
// that was dropped because the stack was full. An end marker on an empty
// stack, or a dropped push with nothing popped, gives one word with
// char_valid low.
// Timing: the input word is latched on acceptance, then the operator
// stack (a chain of shift cells, top at cell 0) does one step per cycle
// unless a stall holds it: one pop and emit, one push, or one discard of
// '('. An operand is emitted directly, an operator popping k entries pops
// and emits them and is then pushed, and an end marker pops and emits the
// stack entries (an empty word on an empty stack). The result sits in an
// output register; the next input word is accepted while it waits.
// A stall on dst_* holds the output register and freezes any step that
// would emit; src_stall stays high until the current word is done.
// Reset empties the stack and the output register.
module infix_to_postfix_converter
	import i2p_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	output logic     src_stall,
	input  i2p_in_t  src_data,
	output logic     dst_valid,
	input  logic     dst_stall,
	output i2p_out_t dst_data
);

	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic             state_q;
	logic [7:0]       ch_q;
	logic             end_q;
	logic [RUN_W-1:0] n_q;
	logic [CW-1:0]    cnt_q;
	logic             out_valid_q;
	i2p_out_t         out_q;

	logic [7:0] cell_data [STACK_DEPTH];
	logic [7:0] top_ch;
	logic [7:0] nxt_ch;
	logic [1:0] p_in;
	logic [1:0] p_top;
	logic [1:0] p_nxt;
	logic       has;
	logic       cnt_one;
	logic       full;
	logic       n_end;
	logic       n_full;
	logic       out_free;
	logic       emit;
	logic       finish;
	logic       go;
	stk_ctl_t   step_ctl;
	stk_ctl_t   ctl;
	i2p_out_t   res;

	// operator stack
	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			logic [7:0] up_d;
			logic [7:0] down_d;
			if (gi == 0) begin : g_top
				assign up_d = ch_q;
			end else begin : g_mid
				assign up_d = cell_data[gi-1];
			end
			if (gi == STACK_DEPTH - 1) begin : g_bot
				assign down_d = 8'h00;
			end else begin : g_inner
				assign down_d = cell_data[gi+1];
			end
			i2p_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.from_up   (up_d),
				.from_down (down_d),
				.entry     (cell_data[gi])
			);
		end
	endgenerate

	assign top_ch   = cell_data[0];
	assign nxt_ch   = cell_data[1];
	assign p_in     = prec_lvl(ch_q);
	assign p_top    = prec_lvl(top_ch);
	assign p_nxt    = prec_lvl(nxt_ch);
	assign has      = cnt_q != '0;
	assign cnt_one  = cnt_q == CW'(1);
	assign full     = cnt_q == CW'(STACK_DEPTH);
	assign n_end    = n_q == RUN_W'(MAX_RUN - 1);
	assign n_full   = n_q == RUN_W'(MAX_RUN);
	assign out_free = !out_valid_q || !dst_stall;

	// one step of the current word; run_last looks ahead at the next entry
	always_comb begin
		emit     = 1'b0;
		finish   = 1'b0;
		step_ctl = '0;
		res      = '0;
		if (end_q) begin
			emit = 1'b1;
			if (has) begin
				res.out_char   = top_ch;
				res.char_valid = 1'b1;
				res.run_last   = cnt_one || n_end;
				res.expr_done  = cnt_one;
				step_ctl.pop   = 1'b1;
				finish         = cnt_one || n_end;
			end else begin
				res.run_last  = 1'b1;
				res.expr_done = 1'b1;
				finish        = 1'b1;
			end
		end else if (is_operand(ch_q)) begin
			emit           = 1'b1;
			res.out_char   = ch_q;
			res.char_valid = 1'b1;
			res.run_last   = 1'b1;
			finish         = 1'b1;
		end else if (ch_q == CH_RPAR) begin
			if (has && top_ch != CH_LPAR && !n_full) begin
				emit           = 1'b1;
				res.out_char   = top_ch;
				res.char_valid = 1'b1;
				res.run_last   = cnt_one || nxt_ch == CH_LPAR || n_end;
				step_ctl.pop   = 1'b1;
			end else begin
				step_ctl.pop = has && top_ch == CH_LPAR;
				finish       = 1'b1;
			end
		end else begin
			if (ch_q != CH_LPAR && has && top_ch != CH_LPAR && p_top >= p_in &&
				!n_full) begin
				emit           = 1'b1;
				res.out_char   = top_ch;
				res.char_valid = 1'b1;
				res.run_last   = cnt_one || nxt_ch == CH_LPAR || p_nxt < p_in ||
					n_end;
				step_ctl.pop   = 1'b1;
			end else if (!full) begin
				step_ctl.push = 1'b1;
				finish        = 1'b1;
			end else begin
				emit         = 1'b1;
				res.run_last = 1'b1;
				res.overflow = 1'b1;
				finish       = 1'b1;
			end
		end
	end

	assign go  = (state_q == ST_BUSY) && (!emit || out_free);
	assign ctl = go ? step_ctl : '0;

	// control, run count and stack count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (src_valid) begin
						state_q <= ST_BUSY;
						n_q     <= '0;
					end
				end
				ST_BUSY: begin
					if (go) begin
						if (finish) begin
							state_q <= ST_IDLE;
						end
						if (step_ctl.pop) begin
							cnt_q <= cnt_q - CW'(1);
						end else if (step_ctl.push) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (emit) begin
							n_q <= n_q + RUN_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// input word latch
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && src_valid) begin
			ch_q  <= src_data.in_char;
			end_q <= src_data.end_mark;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emit) begin
			out_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_q <= res;
		end
	end

	assign src_stall = state_q != ST_IDLE;
	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> has)
		else $error("pop from empty stack");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("push did not grow the stack");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && (dst_data.expr_done || dst_data.overflow) |-> dst_data.run_last)
		else $error("done or overflow word not marked last");

endmodule

/* dv/tb_infix_to_postfix_converter.sv */
module tb_infix_to_postfix_converter;
	timeunit 1ns;
	timeprecision 1ps;

	import i2p_pkg::*;

	localparam int DEPTH     = DEFAULT_STACK_DEPTH;
	localparam int LIMIT     = 200000;
	localparam int HOLD_LEN  = 400;
	localparam int SETTLE    = 40;
	localparam int MAX_PRINT = 100;

	// characters that start the operand ranges
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_LOWA = 8'h61;
	localparam logic [7:0] CH_UPPA = 8'h41;

	localparam logic [7:0] ARITH_OPS [5] =
		'{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};

	// words that can be read off directly
	localparam i2p_out_t W_NONE      = '0;
	localparam i2p_out_t W_EMPTY_END = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0};
	localparam i2p_out_t W_OPND_A    = '{8'h61, 1'b1, 1'b1, 1'b0, 1'b0};
	localparam i2p_out_t W_DROP      = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1};

	typedef struct packed {
		logic [7:0] ch;
		logic       endm;
		logic [4:0] reps;
		logic       typed;
		i2p_out_t   exp;
	} dir_row_t;

	// directed stimulus: char, end marker, repeat count, typed word
	localparam dir_row_t DIR_TAB [0:18] = '{
		'{8'h00,    1'b1, 5'd1,  1'b1, W_EMPTY_END},
		'{8'h61,    1'b0, 5'd1,  1'b1, W_OPND_A},
		'{CH_PLUS,  1'b0, 5'd1,  1'b0, W_NONE},
		'{8'h5a,    1'b0, 5'd1,  1'b0, W_NONE},
		'{CH_STAR,  1'b0, 5'd1,  1'b0, W_NONE},
		'{8'h39,    1'b0, 5'd1,  1'b0, W_NONE},
		'{CH_CARET, 1'b0, 5'd1,  1'b0, W_NONE},
		'{8'h30,    1'b0, 5'd1,  1'b0, W_NONE},
		'{CH_MINUS, 1'b0, 5'd1,  1'b0, W_NONE},
		'{8'h7a,    1'b0, 5'd1,  1'b0, W_NONE},
		'{CH_RPAR,  1'b0, 5'd1,  1'b0, W_NONE},
		'{CH_RPAR,  1'b0, 5'd1,  1'b0, W_NONE},
		'{8'hff,    1'b0, 5'd1,  1'b0, W_NONE},
		'{8'h80,    1'b0, 5'd1,  1'b0, W_NONE},
		'{CH_LPAR,  1'b0, 5'd14, 1'b0, W_NONE},
		'{CH_SLASH, 1'b0, 5'd1,  1'b0, W_NONE},
		'{CH_LPAR,  1'b0, 5'd1,  1'b1, W_DROP},
		'{CH_RPAR,  1'b0, 5'd1,  1'b0, W_NONE},
		'{8'hff,    1'b1, 5'd1,  1'b0, W_NONE}
	};

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     src_valid = 1'b0;
	logic     src_stall;
	i2p_in_t  src_data  = '0;
	logic     dst_valid;
	logic     dst_stall = 1'b0;
	i2p_out_t dst_data;

	// traffic shaping
	bit src_idle_en = 1'b1;
	bit dst_idle_en = 1'b1;
	bit hold_req    = 1'b0;
	bit hold_taken  = 1'b0;
	int hold_left   = 0;

	// operator stack copy and expected postfix words
	logic [7:0] opstk [DEPTH];
	int         opstk_cnt = 0;
	i2p_out_t   run_buf [MAX_RUN];
	i2p_out_t   postfix_q [$];

	int err_cnt   = 0;
	int words_in  = 0;
	int words_out = 0;
	int flushes   = 0;
	int drops     = 0;
	int cyc       = 0;

	infix_to_postfix_converter #(
		.STACK_DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_data (dst_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cyc, postfix_q.size());
			$display("** infix_to_postfix_converter: FAILED **");
			$finish;
		end
	end

	task automatic report_err(input string what, input logic [7:0] got, input logic [7:0] want);
		err_cnt++;
		if (err_cnt <= MAX_PRINT)
			$display("%0t mismatch on %s: got %h want %h", $realtime, what, got, want);
	endtask

	// operator precedence, -1 for anything that is not arithmetic
	function automatic int prec_of_char(input logic [7:0] c);
		if (c == CH_CARET)
			return 3;
		if (c == CH_STAR || c == CH_SLASH)
			return 2;
		if (c == CH_PLUS || c == CH_MINUS)
			return 1;
		return -1;
	endfunction

	function automatic bit is_digit_or_letter(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_ZERO + 8'd9) || (c >= CH_LOWA && c <= CH_LOWA + 8'd25) ||
			(c >= CH_UPPA && c <= CH_UPPA + 8'd25);
	endfunction

	function i2p_out_t pop_top();
		i2p_out_t r;
		r = '0;
		r.out_char = opstk[opstk_cnt - 1];
		r.char_valid = 1'b1;
		opstk_cnt--;
		return r;
	endfunction

	// one shunting-yard step: fills run_buf, returns the number of words
	function int shunt_step(input i2p_in_t w);
		int n;
		int p;
		n = 0;
		if (w.end_mark) begin
			while (opstk_cnt > 0 && n < MAX_RUN) begin
				run_buf[n] = pop_top();
				n++;
			end
			if (n == 0) begin
				run_buf[0] = '0;
				n = 1;
			end
			if (opstk_cnt == 0)
				run_buf[n - 1].expr_done = 1'b1;
		end else if (is_digit_or_letter(w.in_char)) begin
			run_buf[0] = '0;
			run_buf[0].out_char = w.in_char;
			run_buf[0].char_valid = 1'b1;
			n = 1;
		end else if (w.in_char == CH_RPAR) begin
			while (opstk_cnt > 0 && opstk[opstk_cnt - 1] != CH_LPAR && n < MAX_RUN) begin
				run_buf[n] = pop_top();
				n++;
			end
			if (opstk_cnt > 0 && opstk[opstk_cnt - 1] == CH_LPAR)
				opstk_cnt--;
		end else begin
			if (w.in_char != CH_LPAR) begin
				p = prec_of_char(w.in_char);
				while (opstk_cnt > 0 && opstk[opstk_cnt - 1] != CH_LPAR &&
					prec_of_char(opstk[opstk_cnt - 1]) >= p && n < MAX_RUN) begin
					run_buf[n] = pop_top();
					n++;
				end
			end
			if (opstk_cnt < DEPTH) begin
				opstk[opstk_cnt] = w.in_char;
				opstk_cnt++;
			end else if (n == 0) begin
				run_buf[0] = '0;
				run_buf[0].overflow = 1'b1;
				n = 1;
			end else begin
				run_buf[n - 1].overflow = 1'b1;
			end
		end
		if (n > 0)
			run_buf[n - 1].run_last = 1'b1;
		return n;
	endfunction

	function automatic i2p_in_t char_word(input logic [7:0] c, input logic e);
		i2p_in_t w;
		w.in_char = c;
		w.end_mark = e;
		return w;
	endfunction

	function automatic logic [7:0] rand_operand();
		case ($urandom_range(2))
			0: return CH_ZERO + 8'($urandom_range(9));
			1: return CH_LOWA + 8'($urandom_range(25));
			default: return CH_UPPA + 8'($urandom_range(25));
		endcase
	endfunction

	// offer one input word, predict on acceptance
	task automatic send_word(input i2p_in_t w, input bit typed, input i2p_out_t typed_word);
		int n;
		while (src_idle_en && $urandom_range(99) < 36) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= w;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		words_in++;
		n = shunt_step(w);
		if (typed) begin
			postfix_q.push_back(typed_word);
		end else begin
			for (int i = 0; i < n; i++)
				postfix_q.push_back(run_buf[i]);
		end
	endtask

	// well-formed expression with random content, sometimes broken
	task automatic send_expr();
		i2p_in_t seq [$];
		int n_opnd;
		int depth;
		bit no_close;
		n_opnd = $urandom_range(1, 6);
		depth = 0;
		no_close = ($urandom_range(7) == 0);
		for (int i = 0; i < n_opnd; i++) begin
			while (depth < 5 && $urandom_range(3) == 0) begin
				seq.push_back(char_word(CH_LPAR, 1'b0));
				depth++;
			end
			seq.push_back(char_word(rand_operand(), 1'b0));
			while (depth > 0 && $urandom_range(2) == 0) begin
				seq.push_back(char_word(CH_RPAR, 1'b0));
				depth--;
			end
			if (i < n_opnd - 1)
				seq.push_back(char_word(ARITH_OPS[$urandom_range(4)], 1'b0));
		end
		while (!no_close && depth > 0) begin
			seq.push_back(char_word(CH_RPAR, 1'b0));
			depth--;
		end
		if ($urandom_range(7) != 0)
			seq.push_back(char_word(8'($urandom_range(255)), 1'b1));
		foreach (seq[i])
			send_word(seq[i], 1'b0, W_NONE);
	endtask

	// random bytes, stray end markers and runs of '(' that fill the stack
	task automatic send_noise();
		int k;
		k = $urandom_range(3, 12);
		for (int i = 0; i < k; i++) begin
			case ($urandom_range(9))
				0: repeat ($urandom_range(14, 20)) send_word(char_word(CH_LPAR, 1'b0), 1'b0, W_NONE);
				1: send_word(char_word(8'($urandom_range(255)), 1'b1), 1'b0, W_NONE);
				default: send_word(char_word(8'($urandom_range(255)), 1'b0), 1'b0, W_NONE);
			endcase
		end
	endtask

	task automatic send_some();
		if ($urandom_range(3) == 0)
			send_noise();
		else
			send_expr();
	endtask

	// wait until every expected word is back and the block is quiet
	task automatic drain();
		while (postfix_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// output stall: random, a long hold when asked, or none
	always @(posedge clk) begin
		if (hold_left > 0) begin
			dst_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			dst_stall <= 1'b1;
			hold_taken <= 1'b1;
			hold_left <= HOLD_LEN;
		end else begin
			dst_stall <= dst_idle_en && ($urandom_range(99) < 36);
		end
	end

	// check each accepted output word against the oldest prediction
	always @(posedge clk) begin : check_out
		i2p_out_t want;
		if (arst_n && dst_valid && !dst_stall) begin
			words_out++;
			if (dst_data.expr_done)
				flushes++;
			if (dst_data.overflow)
				drops++;
			if (postfix_q.size() == 0) begin
				report_err("unexpected word", dst_data.out_char, 8'h00);
			end else begin
				want = postfix_q.pop_front();
				if (dst_data.out_char !== want.out_char)
					report_err("out_char", dst_data.out_char, want.out_char);
				if (dst_data.char_valid !== want.char_valid)
					report_err("char_valid", 8'(dst_data.char_valid), 8'(want.char_valid));
				if (dst_data.run_last !== want.run_last)
					report_err("run_last", 8'(dst_data.run_last), 8'(want.run_last));
				if (dst_data.expr_done !== want.expr_done)
					report_err("expr_done", 8'(dst_data.expr_done), 8'(want.expr_done));
				if (dst_data.overflow !== want.overflow)
					report_err("overflow", 8'(dst_data.overflow), 8'(want.overflow));
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < $size(DIR_TAB); i++) begin
			for (int k = 0; k < int'(DIR_TAB[i].reps); k++)
				send_word(char_word(DIR_TAB[i].ch, DIR_TAB[i].endm), DIR_TAB[i].typed,
					DIR_TAB[i].exp);
		end

		// random traffic with idling on both sides
		while (words_in < 160)
			send_some();

		// long output hold while words keep coming
		src_idle_en = 1'b0;
		hold_req <= 1'b1;
		repeat (6) send_expr();

		// sender pauses until everything is back
		src_valid <= 1'b0;
		drain();

		// stretch without any idling
		dst_idle_en <= 1'b0;
		while (words_in < 260)
			send_some();

		src_idle_en = 1'b1;
		dst_idle_en <= 1'b1;
		while (words_in < 400)
			send_some();
		src_valid <= 1'b0;
		drain();

		if (postfix_q.size() != 0)
			report_err("words left over", 8'(postfix_q.size()), 8'h00);

		$display("%0d infix words in, %0d postfix words out, %0d complete flushes, %0d drops",
			words_in, words_out, flushes, drops);
		$display("directed edge cases, random expressions and noise, long output hold, drain pause");
		if (err_cnt == 0) begin
			$display("** infix_to_postfix_converter: PASSED **");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("** infix_to_postfix_converter: FAILED **");
		end
		$finish;
	end

endmodule

/* files.f */
hdl/i2p_pkg.sv
hdl/i2p_cell.sv
hdl/infix_to_postfix_converter.sv
dv/tb_infix_to_postfix_converter.sv
